@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the invariant mass unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ rtl/tbim_pkg.sv @@
// Constants and register codes of the three-body invariant mass unit.
`default_nettype none
package tbim_pkg;
  localparam int unsigned MomentumBitsDef = 24;
  localparam int unsigned DMassW          = 16;
  localparam int unsigned MinPzW          = 24;
  localparam int unsigned MassW           = 26;
  localparam int unsigned CfgIdxW         = 2;
  localparam int unsigned CfgDataW        = 24;

  localparam logic [MassW-1:0]    MassMax         = 26'h3FF_FFFF;
  // Kaon mass, 493.677 MeV at 1/8 MeV per step.
  localparam logic [DMassW-1:0]   DMassReset      = 16'd3949;
  localparam logic [MinPzW-1:0]   MinPzReset      = '0;

  localparam logic [CfgIdxW-1:0]  CfgDaughterMass = 2'd0;
  localparam logic [CfgIdxW-1:0]  CfgMinThirdPz   = 2'd1;
endpackage
`default_nettype wire

@@ rtl/tbim_sqrt_pipe.sv @@
// Pipelined integer square root, one root bit per stage, several lanes side by side.
`default_nettype none
module tbim_sqrt_pipe #(
  parameter int unsigned RW    = 34,
  parameter int unsigned LANES = 1,
  parameter int unsigned SW    = 1
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      valid_i,
  input  wire logic [LANES*RW-1:0]       rad_i,
  input  wire logic [SW-1:0]             side_i,
  output logic                           valid_o,
  output logic [LANES*(RW/2)-1:0]        root_o,
  output logic [SW-1:0]                  side_o
);
  localparam int unsigned N = RW / 2;

  logic [N-1:0]  valid_q;
  logic [SW-1:0] side_q [N];
  logic [RW-1:0] rem_q  [N][LANES];
  logic [N-1:0]  root_q [N][LANES];

  for (genvar j = 0; j < N; j++) begin : g_stage
    localparam int unsigned Pos = N - 1 - j;
    localparam logic [N-1:0] PosMask = N'(1) << Pos;
    logic          in_valid;
    logic [SW-1:0] in_side;

    if (j == 0) begin : g_first
      assign in_valid = valid_i;
      assign in_side  = side_i;
    end else begin : g_next
      assign in_valid = valid_q[j-1];
      assign in_side  = side_q[j-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[j] <= 1'b0;
      end else begin
        valid_q[j] <= in_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      side_q[j] <= in_side;
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [RW-1:0] in_rem;
      logic [N-1:0]  in_root;
      logic [RW:0]   trial;
      logic          fits;

      if (j == 0) begin : g_first
        assign in_rem  = rad_i[l*RW +: RW];
        assign in_root = '0;
      end else begin : g_next
        assign in_rem  = rem_q[j-1][l];
        assign in_root = root_q[j-1][l];
      end

      // Trial subtrahend (2*root + 2^pos) * 2^pos; the partial root has no bits at or below pos.
      assign trial = ((RW+1)'(in_root) << (Pos + 1)) + ((RW+1)'(1) << (2 * Pos));
      assign fits  = {1'b0, in_rem} >= trial;

      always_ff @(posedge clk_i) begin
        rem_q[j][l]  <= fits ? (in_rem - trial[RW-1:0]) : in_rem;
        root_q[j][l] <= fits ? (in_root | PosMask) : in_root;
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign root_o[l*N +: N] = root_q[N-1][l];
  end
  assign valid_o = valid_q[N-1];
  assign side_o  = side_q[N-1];
endmodule
`default_nettype wire

@@ rtl/three_body_invariant_mass_unit.sv @@
// Top level of the three-body invariant mass unit.
// Usage:
//   An event (nine signed momentum components) is taken at a rising edge with start_i high
//   and busy_o low. busy_o is always low, so one event can enter every cycle.
//   Each event gives exactly one result, shown for one cycle with valid_o high: accepted_o
//   tells whether the third particle's z momentum passed the cut, mass_o holds the invariant
//   mass (zero for rejected events or a negative radicand, saturated at the field maximum).
//   The two square root pipelines give one root bit per stage, MOMENTUM_BITS+1 and
//   MOMENTUM_BITS+3 stages, and six further register stages hold the squares, sums and
//   the output. Throughput is one event per cycle. Results are delivered in order of entry.
//   The receiver cannot stall; the result strobe is not held.
//   Registers are written over the cfg channel (index 0 daughter mass, index 1 minimum third
//   z momentum; other indexes are ignored). cfg_ready_o is always high. Write them only
//   while no event is in flight.
//   Reset clears the pipeline valid bits and loads the kaon mass and a zero cut.
`default_nettype none
`include "assert_macros.svh"
module three_body_invariant_mass_unit #(
  parameter int unsigned MOMENTUM_BITS = tbim_pkg::MomentumBitsDef
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  output logic                                  busy_o,
  input  wire logic signed [MOMENTUM_BITS-1:0]  px_one_i,
  input  wire logic signed [MOMENTUM_BITS-1:0]  py_one_i,
  input  wire logic signed [MOMENTUM_BITS-1:0]  pz_one_i,
  input  wire logic signed [MOMENTUM_BITS-1:0]  px_two_i,
  input  wire logic signed [MOMENTUM_BITS-1:0]  py_two_i,
  input  wire logic signed [MOMENTUM_BITS-1:0]  pz_two_i,
  input  wire logic signed [MOMENTUM_BITS-1:0]  px_three_i,
  input  wire logic signed [MOMENTUM_BITS-1:0]  py_three_i,
  input  wire logic signed [MOMENTUM_BITS-1:0]  pz_three_i,
  output logic                                  valid_o,
  output logic                                  accepted_o,
  output logic [tbim_pkg::MassW-1:0]            mass_o,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [tbim_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire logic [tbim_pkg::CfgDataW-1:0]    cfg_data_i
);
  import tbim_pkg::*;

  localparam int unsigned MB      = MOMENTUM_BITS;
  localparam int unsigned SqW     = 2 * MB;
  localparam int unsigned MsqW    = 2 * DMassW;
  localparam int unsigned ErW     = 2 * MB + 2;
  localparam int unsigned EW      = ErW / 2;
  localparam int unsigned EtW     = MB + 3;
  localparam int unsigned PtW     = MB + 2;
  localparam int unsigned P2sqW   = 2 * PtW;
  localparam int unsigned MrW     = 2 * EtW;
  localparam int unsigned MW      = MrW / 2;
  localparam int unsigned SatW    = (MW > MassW) ? MW : MassW;
  localparam int unsigned CmpW    = (MB > MinPzW) ? MB : MinPzW;
  localparam int unsigned ESideW  = 1 + 3 * P2sqW;
  localparam int unsigned Latency = 2 * MB + 10;

  // Configuration registers.
  logic [DMassW-1:0]        dmass_q;
  logic signed [MinPzW-1:0] min_pz_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dmass_q  <= DMassReset;
      min_pz_q <= MinPzReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgDaughterMass: dmass_q  <= cfg_data_i[DMassW-1:0];
        CfgMinThirdPz:   min_pz_q <= cfg_data_i[MinPzW-1:0];
        default: ;
      endcase
    end
  end

  // Stage A: component squares, mass square, momentum totals and the cut.
  logic signed [MB-1:0]  p_in [9];
  logic                  a_valid_q, a_acc_q;
  logic [SqW-1:0]        a_sq_q  [9];
  logic [MsqW-1:0]       a_msq_q;
  logic signed [PtW-1:0] a_tot_q [3];

  assign p_in[0] = px_one_i;
  assign p_in[1] = py_one_i;
  assign p_in[2] = pz_one_i;
  assign p_in[3] = px_two_i;
  assign p_in[4] = py_two_i;
  assign p_in[5] = pz_two_i;
  assign p_in[6] = px_three_i;
  assign p_in[7] = py_three_i;
  assign p_in[8] = pz_three_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 9; i++) begin
      a_sq_q[i] <= SqW'(p_in[i] * p_in[i]);
    end
    for (int i = 0; i < 3; i++) begin
      a_tot_q[i] <= PtW'(p_in[i]) + PtW'(p_in[i+3]) + PtW'(p_in[i+6]);
    end
    a_msq_q <= dmass_q * dmass_q;
    a_acc_q <= $signed(CmpW'(pz_three_i)) >= $signed(CmpW'(min_pz_q));
  end

  // Stage B: energy radicands and squares of the momentum totals.
  logic             b_valid_q, b_acc_q;
  logic [3*ErW-1:0] b_rad_q;
  logic [P2sqW-1:0] b_p2sq_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      b_rad_q[k*ErW +: ErW] <= ErW'(a_sq_q[3*k]) + ErW'(a_sq_q[3*k+1])
                             + ErW'(a_sq_q[3*k+2]) + ErW'(a_msq_q);
      b_p2sq_q[k] <= P2sqW'(a_tot_q[k] * a_tot_q[k]);
    end
    b_acc_q <= a_acc_q;
  end

  // Energy roots of the three particles.
  logic            e_valid;
  logic [3*EW-1:0] e_root;
  logic [ESideW-1:0] e_side;

  tbim_sqrt_pipe #(
    .RW    (ErW),
    .LANES (3),
    .SW    (ESideW)
  ) u_energy_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (b_valid_q),
    .rad_i   (b_rad_q),
    .side_i  ({b_acc_q, b_p2sq_q[2], b_p2sq_q[1], b_p2sq_q[0]}),
    .valid_o (e_valid),
    .root_o  (e_root),
    .side_o  (e_side)
  );

  // Stage C: total energy and total momentum square.
  logic           c_valid_q, c_acc_q;
  logic [EtW-1:0] c_etot_q;
  logic [MrW-1:0] c_p2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else begin
      c_valid_q <= e_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    c_etot_q <= EtW'(e_root[0 +: EW]) + EtW'(e_root[EW +: EW]) + EtW'(e_root[2*EW +: EW]);
    c_p2_q   <= MrW'(e_side[0 +: P2sqW]) + MrW'(e_side[P2sqW +: P2sqW])
              + MrW'(e_side[2*P2sqW +: P2sqW]);
    c_acc_q  <= e_side[ESideW-1];
  end

  // Stage D: total energy squared.
  logic           d_valid_q, d_acc_q;
  logic [MrW-1:0] d_e2_q, d_p2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
    end else begin
      d_valid_q <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d_e2_q  <= c_etot_q * c_etot_q;
    d_p2_q  <= c_p2_q;
    d_acc_q <= c_acc_q;
  end

  // Stage E: mass radicand, clamped at zero.
  logic           f_valid_q, f_acc_q;
  logic [MrW-1:0] f_rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else begin
      f_valid_q <= d_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    f_rad_q <= (d_e2_q >= d_p2_q) ? (d_e2_q - d_p2_q) : '0;
    f_acc_q <= d_acc_q;
  end

  logic          m_valid, m_acc;
  logic [MW-1:0] m_root;

  tbim_sqrt_pipe #(
    .RW    (MrW),
    .LANES (1),
    .SW    (1)
  ) u_mass_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_valid_q),
    .rad_i   (f_rad_q),
    .side_i  (f_acc_q),
    .valid_o (m_valid),
    .root_o  (m_root),
    .side_o  (m_acc)
  );

  // Output register: saturation and zeroing of rejected events.
  logic [SatW-1:0]  root_ext;
  logic [MassW-1:0] mass_d, mass_q;
  logic             valid_q, acc_q;

  assign root_ext = SatW'(m_root);

  always_comb begin
    if (!m_acc) begin
      mass_d = '0;
    end else if (root_ext > SatW'(MassMax)) begin
      mass_d = MassMax;
    end else begin
      mass_d = root_ext[MassW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= m_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    mass_q <= mass_d;
    acc_q  <= m_acc;
  end

  assign valid_o    = valid_q;
  assign accepted_o = acc_q;
  assign mass_o     = mass_q;

  `ASSERT_IMPL(a_result_follows_start, clk_i, rst_ni, valid_o, $past(start_i, Latency))
  `ASSERT_IMPL(a_rejected_zero_mass, clk_i, rst_ni, valid_o && !accepted_o, mass_o == '0)
  `ASSERT_NEXT(a_cfg_mass_write, clk_i, rst_ni, cfg_valid_i && (cfg_index_i == CfgDaughterMass), dmass_q == $past(cfg_data_i[DMassW-1:0]))
endmodule
`default_nettype wire

@@ tb/sv/three_body_mass_checker.sv @@
// Checker for the three-body invariant mass unit: predicts each result and compares it.
`timescale 1ns / 100ps
module three_body_mass_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          busy_i,
  input  logic [8:0][23:0]              momentum_i,
  input  logic                          valid_i,
  input  logic                          accepted_i,
  input  logic [tbim_pkg::MassW-1:0]    mass_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [tbim_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [tbim_pkg::CfgDataW-1:0] cfg_data_i,
  output int                            fail_count_o,
  output int                            pending_o
);
  import tbim_pkg::*;

  typedef struct packed {
    logic             accepted;
    logic [MassW-1:0] mass;
  } mass_result_t;

  mass_result_t       mass_due_q[$];
  logic [DMassW-1:0]  dmass_q;
  logic [MinPzW-1:0]  min_pz_q;
  int                 fail_count;
  int                 pending;

  function automatic logic [127:0] floor_root(logic [127:0] x);
    logic [127:0] r;
    logic [127:0] t;
    r = '0;
    for (int i = 40; i >= 0; i--) begin
      t = r | (128'd1 << i);
      if (t * t <= x) r = t;
    end
    return r;
  endfunction

  function automatic mass_result_t predict_mass(logic [8:0][23:0] m, logic [DMassW-1:0] dm,
                                                logic [MinPzW-1:0] cut);
    mass_result_t res;
    longint       comp;
    longint       sum_p[3];
    logic [127:0] e_sq;
    logic [127:0] e_total;
    logic [127:0] e2;
    logic [127:0] p2;
    logic [127:0] root;
    res = '0;
    sum_p = '{0, 0, 0};
    e_total = '0;
    p2 = '0;
    if (longint'($signed(m[8])) < longint'($signed(cut))) return res;
    for (int k = 0; k < 3; k++) begin
      e_sq = 128'(dm) * 128'(dm);
      for (int i = 0; i < 3; i++) begin
        comp = longint'($signed(m[k*3+i]));
        e_sq += 128'(comp * comp);
        sum_p[i] += comp;
      end
      e_total += floor_root(e_sq);
    end
    e2 = e_total * e_total;
    for (int i = 0; i < 3; i++) p2 += 128'(sum_p[i] * sum_p[i]);
    res.accepted = 1'b1;
    if (e2 >= p2) begin
      root = floor_root(e2 - p2);
      res.mass = (root > 128'(MassMax)) ? MassMax : root[MassW-1:0];
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    mass_result_t due;
    mass_result_t pred;
    if (!rst_ni) begin
      dmass_q    <= DMassReset;
      min_pz_q   <= MinPzReset;
      fail_count = 0;
      pending    = 0;
      mass_due_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CfgDaughterMass) dmass_q <= cfg_data_i[DMassW-1:0];
        else if (cfg_index_i == CfgMinThirdPz) min_pz_q <= cfg_data_i[MinPzW-1:0];
      end
      if (start_i && !busy_i) begin
        pred = predict_mass(momentum_i, dmass_q, min_pz_q);
        mass_due_q = {mass_due_q, pred};
      end
      if (valid_i) begin
        if (mass_due_q.size() == 0) begin
          $error("result with no event outstanding: accepted %0d mass %0d",
                 accepted_i, mass_i);
          fail_count++;
        end else begin
          due = mass_due_q.pop_front();
          if (accepted_i !== due.accepted) begin
            $error("accepted: expected %0d, got %0d", due.accepted, accepted_i);
            fail_count++;
          end
          if (mass_i !== due.mass) begin
            $error("mass: expected %0d, got %0d", due.mass, mass_i);
            fail_count++;
          end
        end
      end
      pending = mass_due_q.size();
    end
  end

  assign fail_count_o = fail_count;
  assign pending_o    = pending;

endmodule

@@ tb/sv/tb_three_body_invariant_mass_unit.sv @@
// Stimulus and verdict for the three-body invariant mass unit.
`timescale 1ns / 100ps
module tb_three_body_invariant_mass_unit;
  import tbim_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgSpareTwo   = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareThree = 2'd3;
  localparam int                 DrainCycles   = 70;
  localparam logic [23:0]        PMax          = 24'h7F_FFFF;
  localparam logic [23:0]        PMin          = 24'h80_0000;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start_i;
  logic                 busy_o;
  logic [8:0][23:0]     momentum;
  logic                 valid_o;
  logic                 accepted_o;
  logic [MassW-1:0]     mass_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i;
  logic [CfgDataW-1:0]  cfg_data_i;
  int                   fail_count;
  int                   pending;
  logic [23:0]          cut_now;
  bit                   no_gaps;

  three_body_invariant_mass_unit u_top (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .px_one_i(momentum[0]), .py_one_i(momentum[1]), .pz_one_i(momentum[2]),
    .px_two_i(momentum[3]), .py_two_i(momentum[4]), .pz_two_i(momentum[5]),
    .px_three_i(momentum[6]), .py_three_i(momentum[7]), .pz_three_i(momentum[8]),
    .valid_o, .accepted_o, .mass_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  three_body_mass_checker u_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .momentum_i(momentum),
    .valid_i(valid_o), .accepted_i(accepted_o), .mass_i(mass_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("TEST FAILED");
    $finish;
  end

  task automatic wait_drained();
    start_i <= 1'b0;
    @(posedge clk_i);
    do @(negedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    bit taken;
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end while (!taken);
    cfg_valid_i <= 1'b0;
    if (idx == CfgMinThirdPz) cut_now = data;
  endtask

  task automatic send_event(logic [8:0][23:0] ev);
    bit taken;
    int r;
    int gap;
    momentum <= ev;
    start_i  <= 1'b1;
    do begin
      @(negedge clk_i);
      taken = !busy_o;
      @(posedge clk_i);
    end while (!taken);
    r = $urandom_range(0, 99);
    gap = no_gaps ? 0 : (r < 55) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic logic [23:0] random_component();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 24'($urandom);
      4, 5, 6, 7: return 24'($signed($urandom_range(0, 8192)) - 4096);
      8: begin
        case ($urandom_range(0, 3))
          0: return PMax;
          1: return PMin;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return 24'($signed($urandom_range(0, 6)) - 3);
    endcase
  endfunction

  function automatic logic [8:0][23:0] random_event();
    logic [8:0][23:0] ev;
    for (int i = 0; i < 9; i++) ev[i] = random_component();
    // Put the third z momentum on the cut or one step either side of it now and then.
    if ($urandom_range(0, 3) == 0) ev[8] = cut_now + 24'($urandom_range(0, 2)) - 24'd1;
    return ev;
  endfunction

  task automatic run_phase(int count);
    no_gaps = ($urandom_range(0, 2) == 0);
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) wait_drained();
      if (n == count / 4) no_gaps = !no_gaps;
      send_event(random_event());
    end
  endtask

  initial begin
    logic [8:0][23:0] ev;
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    momentum    = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CfgDaughterMass;
    cfg_data_i  = '0;
    cut_now     = MinPzReset;
    no_gaps     = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed events under the reset settings.
    send_event('0);
    send_event({9{PMax}});
    send_event({9{PMin}});
    send_event({{3{PMin}}, {3{PMax}}, {3{PMin}}});
    send_event({{3{PMax}}, {3{PMin}}, {3{PMax}}});
    send_event({PMin, PMax, PMin, PMin, PMax, PMax, PMax, PMin, PMax});
    ev = '0; ev[8] = '1;          // just below a zero cut
    send_event(ev);
    ev = '0; ev[8] = PMin;
    send_event(ev);
    ev = '0; ev[0] = 24'd1000; ev[3] = -24'sd1000;
    send_event(ev);

    // With zero daughter mass, flooring each energy can leave a negative radicand.
    write_reg(CfgDaughterMass, 24'd0);
    send_event({24'd0, 24'd1, 24'd1, 24'd0, 24'd1, 24'd1, 24'd0, 24'd1, 24'd1});
    send_event({24'd2, 24'd1, 24'd1, 24'd2, 24'd1, 24'd1, 24'd2, 24'd1, 24'd1});
    send_event('0);
    write_reg(CfgDaughterMass, 24'd65535);
    send_event('0);
    send_event({9{PMax}});
    write_reg(CfgMinThirdPz, 24'h7F_FFFF);
    ev = '0; ev[8] = PMax;
    send_event(ev);
    ev[8] = PMax - 24'd1;
    send_event(ev);
    write_reg(CfgMinThirdPz, 24'h80_0000);
    ev[8] = PMin;
    send_event(ev);

    // Random phases across several register settings.
    write_reg(CfgDaughterMass, DMassReset);
    write_reg(CfgMinThirdPz, MinPzReset);
    run_phase(290);
    write_reg(CfgDaughterMass, 24'd0);
    write_reg(CfgMinThirdPz, 24'h80_0000);
    run_phase(290);
    write_reg(CfgDaughterMass, 24'd65535);
    write_reg(CfgMinThirdPz, 24'h7F_FFFF);
    run_phase(290);
    write_reg(CfgDaughterMass, 24'($urandom_range(0, 65535)));
    write_reg(CfgMinThirdPz, 24'($urandom));
    write_reg(CfgSpareTwo, 24'($urandom));
    write_reg(CfgSpareThree, 24'($urandom));
    run_phase(290);
    write_reg(CfgDaughterMass, 24'd1);
    write_reg(CfgMinThirdPz, -24'sd100);
    run_phase(290);
    write_reg(CfgDaughterMass, 24'($urandom_range(0, 65535)));
    write_reg(CfgMinThirdPz, 24'($signed($urandom_range(0, 20000)) - 10000));
    run_phase(290);

    wait_drained();
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
